### hw/rtl/fvfl_pkg.sv
// Shared types, constants and helpers for the FAT32 volume file locator.
// No dependencies; the field capture unit and the top level use this package.
package fvfl_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned EntrySlots  = 16;
  localparam int unsigned SectorShift = $clog2(SectorBytes);

  localparam logic [8:0] LAST_INDEX    = 9'd511;
  localparam logic [8:0] MBR_PART_OFS  = 9'd454;
  localparam logic [8:0] BPB_BPS_OFS   = 9'd11;
  localparam logic [8:0] BPB_SPC_OFS   = 9'd13;
  localparam logic [8:0] BPB_RSVD_OFS  = 9'd14;
  localparam logic [8:0] BPB_NFATS_OFS = 9'd16;
  localparam logic [8:0] BPB_FATSZ_OFS = 9'd36;
  localparam logic [8:0] BPB_ROOTCL_OFS = 9'd44;
  localparam logic [4:0] DIR_CLHI_OFS  = 5'd20;
  localparam logic [4:0] DIR_CLLO_OFS  = 5'd26;
  localparam logic [4:0] DIR_SIZE_OFS  = 5'd28;
  localparam logic [31:0] FIRST_CLUSTER = 32'd2;
  localparam logic [15:0] SECTOR_SIZE_OK = 16'(SectorBytes);

  typedef enum logic [1:0] {
    OP_MBR     = 2'd0,
    OP_BOOT    = 2'd1,
    OP_DIR     = 2'd2,
    OP_DIR_REQ = 2'd3
  } op_e;

  // Volume geometry and current directory entry, as captured from sector bytes
  typedef struct packed {
    logic [31:0] partition_start;
    logic [15:0] sector_size;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic [31:0] fat_length;
    logic [31:0] root_cluster;
    logic [31:0] entry_cluster;
    logic [31:0] entry_size;
  } geom_t;

  // Card read address of a sector: sector number or byte offset
  function automatic logic [31:0] card_addr(logic block_addr, logic [31:0] sector);
    card_addr = block_addr ? sector : (sector << SectorShift);
  endfunction

endpackage

### hw/rtl/fvfl_fields.sv
// Field capture for the FAT32 volume file locator: writes sector bytes into
// the geometry and directory entry registers. Depends on fvfl_pkg.
module fvfl_fields (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cap_en_i,
  input  fvfl_pkg::op_e       op_i,
  input  logic [8:0]          byte_index_i,
  input  logic [7:0]          data_byte_i,
  input  logic [3:0]          entry_slot_i,
  output fvfl_pkg::geom_t     geom_o,
  output logic [31:0]         entry_size_next_o
);

  fvfl_pkg::geom_t geom_d, geom_q;

  logic [8:0] mbr_off;
  logic [4:0] rel;
  logic       in_slot;

  function automatic logic [31:0] put32(logic [31:0] r, logic [1:0] lane, logic [7:0] b);
    logic [31:0] t;
    t = r;
    t[lane*8 +: 8] = b;
    return t;
  endfunction

  function automatic logic [15:0] put16(logic [15:0] r, logic lane, logic [7:0] b);
    logic [15:0] t;
    t = r;
    t[lane*8 +: 8] = b;
    return t;
  endfunction

  assign mbr_off = byte_index_i - fvfl_pkg::MBR_PART_OFS;
  assign rel     = byte_index_i[4:0];
  assign in_slot = (byte_index_i[8:5] == entry_slot_i);

  always_comb begin
    geom_d = geom_q;
    unique case (op_i)
      fvfl_pkg::OP_MBR: begin
        if (byte_index_i >= fvfl_pkg::MBR_PART_OFS &&
            byte_index_i <= fvfl_pkg::MBR_PART_OFS + 9'd3) begin
          geom_d.partition_start = put32(geom_q.partition_start, mbr_off[1:0], data_byte_i);
        end
      end
      fvfl_pkg::OP_BOOT: begin
        case (byte_index_i) inside
          fvfl_pkg::BPB_BPS_OFS, fvfl_pkg::BPB_BPS_OFS + 9'd1: begin
            geom_d.sector_size = put16(geom_q.sector_size, ~byte_index_i[0], data_byte_i);
          end
          fvfl_pkg::BPB_SPC_OFS: geom_d.cluster_sectors = data_byte_i;
          fvfl_pkg::BPB_RSVD_OFS, fvfl_pkg::BPB_RSVD_OFS + 9'd1: begin
            geom_d.reserved_count = put16(geom_q.reserved_count, byte_index_i[0], data_byte_i);
          end
          fvfl_pkg::BPB_NFATS_OFS: geom_d.fat_copies = data_byte_i;
          [fvfl_pkg::BPB_FATSZ_OFS : fvfl_pkg::BPB_FATSZ_OFS + 9'd3]: begin
            geom_d.fat_length = put32(geom_q.fat_length, byte_index_i[1:0], data_byte_i);
          end
          [fvfl_pkg::BPB_ROOTCL_OFS : fvfl_pkg::BPB_ROOTCL_OFS + 9'd3]: begin
            geom_d.root_cluster = put32(geom_q.root_cluster, byte_index_i[1:0], data_byte_i);
          end
          default: ;
        endcase
      end
      fvfl_pkg::OP_DIR: begin
        if (in_slot) begin
          if (rel == fvfl_pkg::DIR_CLHI_OFS || rel == fvfl_pkg::DIR_CLHI_OFS + 5'd1) begin
            geom_d.entry_cluster = put32(geom_q.entry_cluster, {1'b1, rel[0]}, data_byte_i);
          end else if (rel == fvfl_pkg::DIR_CLLO_OFS ||
                       rel == fvfl_pkg::DIR_CLLO_OFS + 5'd1) begin
            geom_d.entry_cluster = put32(geom_q.entry_cluster, {1'b0, rel[0]}, data_byte_i);
          end else if (rel >= fvfl_pkg::DIR_SIZE_OFS) begin
            geom_d.entry_size = put32(geom_q.entry_size, rel[1:0], data_byte_i);
          end
        end
      end
      fvfl_pkg::OP_DIR_REQ: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= '0;
    end else if (cap_en_i) begin
      geom_q <= geom_d;
    end
  end

  assign geom_o            = geom_q;
  assign entry_size_next_o = geom_d.entry_size;

endmodule

### hw/rtl/fat32_volume_file_locator.sv
// FAT32 volume file locator: boot record, boot sector and directory entry
// parser with an input register and a result register. Depends on fvfl_pkg
// and fvfl_fields.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tagged sector byte or a
//   directory sector request per transfer. Sector bytes give a result only
//   at byte index 511; a directory sector request always gives one.
//   Output channel (out_valid_o/out_ready_i) carries one result per transfer.
//   Each item passes the input register, where its field is captured and its
//   result is formed, and the result is then held in the output register.
//   Throughput: one input transfer per cycle while in_ready_o is high; bytes
//   with no result leave the input register after their field capture.
//   When the receiver stalls, one result waits in the output register and a
//   second in the input register; in_ready_o then drops until the output
//   register is taken. Bytes with no result pass while only the output waits.
//   Reset clears all captured fields, the computed data and root start, the
//   addressing mode and both valid bits. cfg_we_i writes the addressing mode
//   bit (1 = sector, 0 = byte addresses); users do so only while idle, unchecked.
module fat32_volume_file_locator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [8:0]  byte_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [3:0]  entry_slot_i,
  input  logic [7:0]  dir_sector_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] first_value_o,
  output logic [31:0] second_value_o,
  output logic        size_error_o,
  output logic        no_file_o
);

  logic block_addr_q;

  // Input register
  logic                s1_v_q;
  fvfl_pkg::op_e       s1_op_q;
  logic [8:0]          s1_idx_q;
  logic [7:0]          s1_byte_q;
  logic [3:0]          s1_slot_q;
  logic [7:0]          s1_dsec_q;

  // Output register
  logic                out_v_q;
  fvfl_pkg::op_e       out_kind_q;
  logic [31:0]         out_f_q, out_s_q;
  logic                out_serr_q, out_nofile_q;
  logic [31:0]         out_f_d, out_s_d;
  logic                out_serr_d, out_nofile_d;

  logic [31:0] data_start_q, root_start_q;
  logic [31:0] data_start_d, root_start_d;

  logic out_rdy, rdy1;
  logic s1_move, s1_res, s1_take;

  fvfl_pkg::geom_t geom;
  logic [31:0]     entry_size_next;

  logic [31:0] mul_a, mul_b;

  // Handshake: the input register empties unless its result waits for the output
  assign out_rdy    = !out_v_q || out_ready_i;
  assign s1_res     = (s1_op_q == fvfl_pkg::OP_DIR_REQ) || (s1_idx_q == fvfl_pkg::LAST_INDEX);
  assign s1_move    = s1_v_q && (!s1_res || out_rdy);
  assign s1_take    = s1_move && s1_res;
  assign rdy1       = !s1_v_q || s1_move;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_addr_q <= 1'b0;
    end else if (cfg_we_i) begin
      block_addr_q <= cfg_wdata_i;
    end
  end

  fvfl_fields u_fields (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cap_en_i         (s1_move),
    .op_i             (s1_op_q),
    .byte_index_i     (s1_idx_q),
    .data_byte_i      (s1_byte_q),
    .entry_slot_i     (s1_slot_q),
    .geom_o           (geom),
    .entry_size_next_o(entry_size_next)
  );

  // The multiplied fields never change on a final byte, so the stored
  // values are used directly.
  always_comb begin
    if (s1_op_q == fvfl_pkg::OP_DIR) begin
      mul_a = 32'((geom.entry_cluster - fvfl_pkg::FIRST_CLUSTER) *
                  {24'd0, geom.cluster_sectors});
    end else begin
      mul_a = 32'({24'd0, geom.fat_copies} * geom.fat_length);
    end
    mul_b = 32'((geom.root_cluster - fvfl_pkg::FIRST_CLUSTER) *
                {24'd0, geom.cluster_sectors});
    data_start_d = geom.partition_start + mul_a + {16'd0, geom.reserved_count};
    root_start_d = mul_b + data_start_d;
  end

  always_comb begin
    out_f_d      = '0;
    out_s_d      = '0;
    out_serr_d   = 1'b0;
    out_nofile_d = 1'b0;
    unique case (s1_op_q)
      fvfl_pkg::OP_MBR: out_f_d = fvfl_pkg::card_addr(block_addr_q, geom.partition_start);
      fvfl_pkg::OP_BOOT: begin
        out_f_d    = data_start_d;
        out_s_d    = root_start_d;
        out_serr_d = (geom.sector_size != fvfl_pkg::SECTOR_SIZE_OK);
      end
      fvfl_pkg::OP_DIR: begin
        if (geom.entry_cluster == '0) begin
          out_nofile_d = 1'b1;
        end else begin
          out_f_d = fvfl_pkg::card_addr(block_addr_q, 32'd1 + data_start_q + mul_a);
          out_s_d = {9'd0, entry_size_next[31:fvfl_pkg::SectorShift]} + 32'd1;
        end
      end
      fvfl_pkg::OP_DIR_REQ: begin
        out_f_d = fvfl_pkg::card_addr(block_addr_q, root_start_q + {24'd0, s1_dsec_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      data_start_q <= '0;
      root_start_q <= '0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (out_rdy) out_v_q <= s1_take;
      if (s1_take && s1_op_q == fvfl_pkg::OP_BOOT) begin
        data_start_q <= data_start_d;
        root_start_q <= root_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      s1_op_q   <= fvfl_pkg::op_e'(op_i);
      s1_idx_q  <= byte_index_i;
      s1_byte_q <= data_byte_i;
      s1_slot_q <= entry_slot_i;
      s1_dsec_q <= dir_sector_i;
    end
    if (s1_take) begin
      out_kind_q   <= s1_op_q;
      out_f_q      <= out_f_d;
      out_s_q      <= out_s_d;
      out_serr_q   <= out_serr_d;
      out_nofile_q <= out_nofile_d;
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = out_kind_q;
  assign first_value_o  = out_f_q;
  assign second_value_o = out_s_q;
  assign size_error_o   = out_serr_q;
  assign no_file_o      = out_nofile_q;

  a_nofile_only_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_file_o |-> kind_o == fvfl_pkg::OP_DIR)
    else $error("no_file set on a result other than a directory entry");

  a_nofile_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_file_o |-> first_value_o == '0 && second_value_o == '0)
    else $error("empty directory entry carries nonzero values");

  a_serr_only_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> kind_o == fvfl_pkg::OP_BOOT)
    else $error("size_error set on a result other than a boot sector");

  a_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == fvfl_pkg::OP_MBR || kind_o == fvfl_pkg::OP_DIR_REQ)
      |-> second_value_o == '0)
    else $error("second_value nonzero on a boot record or directory request");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(out_f_q) && $stable(out_s_q) &&
      $stable(out_kind_q))
    else $error("stalled result changed");

endmodule
